FILE: src/assert_macros.svh
// ---------------------------------------------------------------------------
// assert_macros.svh
// Assertion shorthands for the checker file of this block.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, ignored while reset is held.
`define CVBD_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("cvbd assertion failed");

// Next-cycle implication, ignored while reset is held.
`define CVBD_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("cvbd assertion failed");

// Next-cycle implication that also holds through reset.
`define CVBD_ASSERT_NEXT_ALWAYS(lbl, clk, ante, cons) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("cvbd assertion failed");

`endif

FILE: src/cvbd_pkg.sv
// ---------------------------------------------------------------------------
// cvbd_pkg
// Types and constants of the CPU/video bus decoder.
// ---------------------------------------------------------------------------
`default_nettype none

package cvbd_pkg;

  // Default store sizes
  localparam int WORK_RAM_BYTES_DEF  = 2048;
  localparam int NAMETABLE_BYTES_DEF = 2048;
  localparam int PALETTE_ENTRIES_DEF = 32;

  // Stream widths
  localparam int IN_TDATA_W  = 48;
  localparam int IN_TUSER_W  = 2;
  localparam int OUT_TDATA_W = 32;
  localparam int OUT_TUSER_W = 1;

  // CPU bus map
  localparam logic [15:0] WRAM_TOP  = 16'h1FFF;
  localparam logic [15:0] VREG_TOP  = 16'h3FFF;
  localparam logic [15:0] IO_TOP    = 16'h401F;
  localparam logic [15:0] PAD1_PORT = 16'h4016;
  localparam logic [15:0] PAD2_PORT = 16'h4017;

  // Video bus map (14-bit address)
  localparam logic [13:0] VBUS_PAT_TOP  = 14'h1FFF;
  localparam logic [13:0] VBUS_PAL_BASE = 14'h3F00;

  localparam logic [7:0]  OPEN_BUS_BYTE   = 8'h7F;
  localparam logic [7:0]  STATUS_KEEP     = 8'h7F;
  localparam logic [7:0]  PAD_STROBE      = 8'h01;
  localparam logic [15:0] VADDR_STEP_ONE  = 16'd1;
  localparam logic [15:0] VADDR_STEP_WIDE = 16'd32;
  localparam int          CTRL_INC_BIT    = 2;

  typedef enum logic [1:0] {
    FUNC_READ   = 2'd0,
    FUNC_WRITE  = 2'd1,
    FUNC_STATUS = 2'd2
  } func_t;

  typedef enum logic [2:0] {
    VREG_CTRL   = 3'd0,
    VREG_MASK   = 3'd1,
    VREG_STATUS = 3'd2,
    VREG_SPRITE = 3'd3,
    VREG_OAM    = 3'd4,
    VREG_SCROLL = 3'd5,
    VREG_ADDR   = 3'd6,
    VREG_DATA   = 3'd7
  } vreg_t;

  // How the result byte is formed in the second stage
  typedef enum logic [1:0] {
    KIND_NONE = 2'd0,
    KIND_BYTE = 2'd1,
    KIND_WRAM = 2'd2,
    KIND_DATA = 2'd3
  } kind_t;

  typedef struct packed {
    kind_t       kind;
    logic        from_nt;    // data-port refill comes from nametable RAM
    logic        pal_range;  // data-port read returns the refilled byte
    logic [7:0]  data;
    logic        csel;
    logic        cspace;
    logic [15:0] caddr;
    logic        cwrite;
    logic        bad;
  } stage_t;

endpackage

`default_nettype wire

FILE: src/cvbd_ram.sv
// ---------------------------------------------------------------------------
// cvbd_ram
// Simple dual-port RAM, one write and one registered read per cycle.
// ---------------------------------------------------------------------------
`default_nettype none

module cvbd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2048
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    // hold the last read word until the next read
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

FILE: src/cpu_video_bus_decoder_unit.sv
// ---------------------------------------------------------------------------
// cpu_video_bus_decoder_unit
// CPU bus decoder: work RAM, video registers with nametable and palette,
// joypad shift registers and cartridge forwarding.
// ---------------------------------------------------------------------------
//
//  channel | dir | fields
//  --------+-----+----------------------------------------------------------
//  in_*    | in  | tuser: func; tdata: addr, wdata, ext_data, pad1/pad2 buttons
//  out_*   | out | tuser: cart_space; tdata: rdata, cart_select, cart_addr,
//          |     |        cart_write, bad_register
//
//  - One item per cycle sustained while the output is not stalled; an
//    accepted item is captured in the accept stage register and then in
//    the result register, whose valid flag drives out_tvalid.
//  - The accept stage updates all other registers and issues the single RAM
//    read or write; the second stage forms rdata and refills the read buffer.
//  - After reset a clearing pass zeroes both RAMs (2 KiB each by default),
//    one entry of each per cycle; in_tready stays low until it has covered
//    max(WORK_RAM_BYTES, NAMETABLE_BYTES) entries.
//  - rst_n is synchronous and active low.
//  - A stalled output holds the result register and, through it, the
//    second stage and in_tready.
//
`default_nettype none

module cpu_video_bus_decoder_unit
  import cvbd_pkg::*;
#(
  parameter int WORK_RAM_BYTES  = WORK_RAM_BYTES_DEF,
  parameter int NAMETABLE_BYTES = NAMETABLE_BYTES_DEF,
  parameter int PALETTE_ENTRIES = PALETTE_ENTRIES_DEF
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  // [15:0] addr, [23:16] wdata, [31:24] ext_data, [39:32] pad1_buttons,
  // [47:40] pad2_buttons
  input  wire logic [IN_TDATA_W-1:0]  in_tdata,
  // [1:0] func
  input  wire logic [IN_TUSER_W-1:0]  in_tuser,
  input  wire logic                   in_tvalid,
  output logic                        in_tready,
  // [7:0] rdata, [8] cart_select, [24:9] cart_addr, [25] cart_write,
  // [26] bad_register, [31:27] zero
  output logic [OUT_TDATA_W-1:0]      out_tdata,
  // [0] cart_space
  output logic [OUT_TUSER_W-1:0]      out_tuser,
  output logic                        out_tvalid,
  input  wire logic                   out_tready
);

  localparam int WA_W      = $clog2(WORK_RAM_BYTES);
  localparam int NA_W      = $clog2(NAMETABLE_BYTES);
  localparam int PA_W      = $clog2(PALETTE_ENTRIES);
  localparam int CLR_DEPTH = (WORK_RAM_BYTES > NAMETABLE_BYTES) ?
                             WORK_RAM_BYTES : NAMETABLE_BYTES;
  localparam int CLR_W     = $clog2(CLR_DEPTH);
  localparam logic [CLR_W-1:0] CLR_LAST  = CLR_W'(CLR_DEPTH - 1);
  localparam logic [CLR_W:0]   WRAM_SIZE = (CLR_W+1)'(WORK_RAM_BYTES);
  localparam logic [CLR_W:0]   NT_SIZE   = (CLR_W+1)'(NAMETABLE_BYTES);

  // Input fields
  logic [15:0] addr;
  logic [7:0]  wdata, ext_data, pad1_buttons, pad2_buttons;
  func_t       func;

  assign addr         = in_tdata[15:0];
  assign wdata        = in_tdata[23:16];
  assign ext_data     = in_tdata[31:24];
  assign pad1_buttons = in_tdata[39:32];
  assign pad2_buttons = in_tdata[47:40];
  assign func         = func_t'(in_tuser);

  // Architectural registers
  logic [7:0]  video_control_r, video_control_nxt;
  logic [7:0]  video_mask_r, video_mask_nxt;
  logic [7:0]  video_status_r, video_status_nxt;
  logic [7:0]  sprite_address_r, sprite_address_nxt;
  logic [15:0] scroll_shift_r, scroll_shift_nxt;
  logic [15:0] video_address_r, video_address_nxt;
  logic [7:0]  read_buffer_r, read_buffer_nxt;
  logic [7:0]  pad1_shift_r, pad1_shift_nxt;
  logic [7:0]  pad2_shift_r, pad2_shift_nxt;
  logic [7:0]  palette_r [PALETTE_ENTRIES];

  // Clearing pass
  logic             clr_active_r, clr_active_nxt;
  logic [CLR_W-1:0] clr_cnt_r, clr_cnt_nxt;

  // Pipeline
  logic   s1_valid_r, s1_valid_nxt;
  stage_t s1_r, s1_nxt;
  logic   s1_go;
  logic   accept;
  logic                   out_valid_r;
  logic [OUT_TDATA_W-1:0] out_tdata_r;
  logic [OUT_TUSER_W-1:0] out_tuser_r;

  // Decode
  logic        is_wram, is_vreg, is_io;
  vreg_t       vreg;
  logic [13:0] va;
  logic        va_pat, va_pal;
  logic [PA_W-1:0] pal_idx;
  logic [15:0] vaddr_step;

  // RAM ports
  logic            wram_we, wram_re, nt_we, nt_re, pal_we;
  logic            wram_ram_we, nt_ram_we;
  logic [WA_W-1:0] wram_waddr;
  logic [NA_W-1:0] nt_waddr;
  logic [7:0]      wram_wdata, nt_wdata;
  logic [7:0]      wram_dout, nt_dout;

  // Second-stage result
  logic [7:0] new_buf;
  logic [7:0] res_rdata;

  assign s1_go     = !out_valid_r || out_tready;
  assign in_tready = !clr_active_r && (!s1_valid_r || s1_go);
  assign accept    = in_tvalid && in_tready;

  assign is_wram = (addr <= WRAM_TOP);
  assign is_vreg = !is_wram && (addr <= VREG_TOP);
  assign is_io   = (addr > VREG_TOP) && (addr <= IO_TOP);
  assign vreg    = vreg_t'(addr[2:0]);

  // Video bus address, mirrored to 14 bits
  assign va      = video_address_r[13:0];
  assign va_pat  = (va <= VBUS_PAT_TOP);
  assign va_pal  = (va >= VBUS_PAL_BASE);
  // Entries that are a multiple of four fold onto the background copies
  assign pal_idx = (va[1:0] == 2'b00) ? {1'b0, va[PA_W-2:0]} : va[PA_W-1:0];
  assign vaddr_step = video_control_r[CTRL_INC_BIT] ? VADDR_STEP_WIDE
                                                    : VADDR_STEP_ONE;

  // Accept stage: register updates, RAM access, second-stage capture
  always_comb begin
    video_control_nxt  = video_control_r;
    video_mask_nxt     = video_mask_r;
    video_status_nxt   = video_status_r;
    sprite_address_nxt = sprite_address_r;
    scroll_shift_nxt   = scroll_shift_r;
    video_address_nxt  = video_address_r;
    pad1_shift_nxt     = pad1_shift_r;
    pad2_shift_nxt     = pad2_shift_r;
    wram_we = 1'b0;
    wram_re = 1'b0;
    nt_we   = 1'b0;
    nt_re   = 1'b0;
    pal_we  = 1'b0;
    s1_nxt  = '0;
    s1_nxt.kind = KIND_NONE;

    if (accept) begin
      case (func)
        FUNC_STATUS: begin
          video_status_nxt = wdata;
        end
        FUNC_READ: begin
          if (is_wram) begin
            wram_re     = 1'b1;
            s1_nxt.kind = KIND_WRAM;
          end else if (is_vreg) begin
            case (vreg)
              VREG_STATUS: begin
                s1_nxt.kind       = KIND_BYTE;
                s1_nxt.data       = video_status_r;
                video_status_nxt  = video_status_r & STATUS_KEEP;
                video_address_nxt = '0;
              end
              VREG_DATA: begin
                s1_nxt.kind      = KIND_DATA;
                s1_nxt.pal_range = va_pal;
                if (va_pat) begin
                  // refill from pattern space through the cartridge
                  s1_nxt.data   = ext_data;
                  s1_nxt.csel   = 1'b1;
                  s1_nxt.cspace = 1'b1;
                  s1_nxt.caddr  = {2'b00, va};
                end else if (!va_pal) begin
                  nt_re          = 1'b1;
                  s1_nxt.from_nt = 1'b1;
                end else begin
                  s1_nxt.data = palette_r[pal_idx];
                end
                video_address_nxt = video_address_r + vaddr_step;
              end
              default: begin
                s1_nxt.kind = KIND_BYTE;
                s1_nxt.data = OPEN_BUS_BYTE;
              end
            endcase
          end else if (is_io) begin
            s1_nxt.kind = KIND_BYTE;
            if (addr == PAD1_PORT) begin
              s1_nxt.data    = {7'b0, pad1_shift_r[0]};
              pad1_shift_nxt = pad1_shift_r >> 1;
            end else if (addr == PAD2_PORT) begin
              s1_nxt.data    = {7'b0, pad2_shift_r[0]};
              pad2_shift_nxt = pad2_shift_r >> 1;
            end
          end else begin
            s1_nxt.kind  = KIND_BYTE;
            s1_nxt.data  = ext_data;
            s1_nxt.csel  = 1'b1;
            s1_nxt.caddr = addr;
          end
        end
        FUNC_WRITE: begin
          if (is_wram) begin
            wram_we = 1'b1;
          end else if (is_vreg) begin
            case (vreg)
              VREG_CTRL:   video_control_nxt  = wdata;
              VREG_MASK:   video_mask_nxt     = wdata;
              VREG_SPRITE: sprite_address_nxt = wdata;
              VREG_SCROLL: scroll_shift_nxt   = {scroll_shift_r[7:0], wdata};
              VREG_ADDR:   video_address_nxt  = {video_address_r[7:0], wdata};
              VREG_DATA: begin
                // pattern-space writes are dropped
                if (va_pal) begin
                  pal_we = 1'b1;
                end else if (!va_pat) begin
                  nt_we = 1'b1;
                end
                video_address_nxt = video_address_r + vaddr_step;
              end
              default: s1_nxt.bad = 1'b1;
            endcase
          end else if (is_io) begin
            if (addr == PAD1_PORT && wdata == PAD_STROBE) begin
              pad1_shift_nxt = pad1_buttons;
              pad2_shift_nxt = pad2_buttons;
            end
          end else begin
            s1_nxt.csel   = 1'b1;
            s1_nxt.caddr  = addr;
            s1_nxt.cwrite = 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

  // Clearing pass owns both write ports until it ends
  always_comb begin
    clr_active_nxt = clr_active_r;
    clr_cnt_nxt    = clr_cnt_r;
    if (clr_active_r) begin
      clr_cnt_nxt = clr_cnt_r + 1'b1;
      if (clr_cnt_r == CLR_LAST) begin
        clr_active_nxt = 1'b0;
      end
    end
  end

  assign wram_ram_we = clr_active_r ? ({1'b0, clr_cnt_r} < WRAM_SIZE) : wram_we;
  assign nt_ram_we   = clr_active_r ? ({1'b0, clr_cnt_r} < NT_SIZE) : nt_we;
  assign wram_waddr  = clr_active_r ? clr_cnt_r[WA_W-1:0] : addr[WA_W-1:0];
  assign nt_waddr    = clr_active_r ? clr_cnt_r[NA_W-1:0] : va[NA_W-1:0];
  assign wram_wdata  = clr_active_r ? 8'h00 : wdata;
  assign nt_wdata    = clr_active_r ? 8'h00 : wdata;

  cvbd_ram #(
    .WIDTH (8),
    .DEPTH (WORK_RAM_BYTES)
  ) u_wram (
    .clk   (clk),
    .we    (wram_ram_we),
    .waddr (wram_waddr),
    .wdata (wram_wdata),
    .re    (wram_re),
    .raddr (addr[WA_W-1:0]),
    .rdata (wram_dout)
  );

  cvbd_ram #(
    .WIDTH (8),
    .DEPTH (NAMETABLE_BYTES)
  ) u_nt_ram (
    .clk   (clk),
    .we    (nt_ram_we),
    .waddr (nt_waddr),
    .wdata (nt_wdata),
    .re    (nt_re),
    .raddr (va[NA_W-1:0]),
    .rdata (nt_dout)
  );

  // Second stage: form the result byte, refill the read buffer
  always_comb begin
    new_buf         = s1_r.from_nt ? nt_dout : s1_r.data;
    read_buffer_nxt = read_buffer_r;
    case (s1_r.kind)
      KIND_BYTE: res_rdata = s1_r.data;
      KIND_WRAM: res_rdata = wram_dout;
      KIND_DATA: begin
        // palette reads bypass the buffer and return the fresh byte
        res_rdata = s1_r.pal_range ? new_buf : read_buffer_r;
        if (s1_valid_r && s1_go) begin
          read_buffer_nxt = new_buf;
        end
      end
      default: res_rdata = 8'h00;
    endcase
  end

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (accept) begin
      s1_valid_nxt = 1'b1;
    end else if (s1_go) begin
      s1_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      video_control_r  <= '0;
      video_mask_r     <= '0;
      video_status_r   <= '0;
      sprite_address_r <= '0;
      scroll_shift_r   <= '0;
      video_address_r  <= '0;
      read_buffer_r    <= '0;
      pad1_shift_r     <= '0;
      pad2_shift_r     <= '0;
      clr_active_r     <= 1'b1;
      clr_cnt_r        <= '0;
      s1_valid_r       <= 1'b0;
      out_valid_r      <= 1'b0;
      for (int i = 0; i < PALETTE_ENTRIES; i++) begin
        palette_r[i] <= '0;
      end
    end else begin
      video_control_r  <= video_control_nxt;
      video_mask_r     <= video_mask_nxt;
      video_status_r   <= video_status_nxt;
      sprite_address_r <= sprite_address_nxt;
      scroll_shift_r   <= scroll_shift_nxt;
      video_address_r  <= video_address_nxt;
      read_buffer_r    <= read_buffer_nxt;
      pad1_shift_r     <= pad1_shift_nxt;
      pad2_shift_r     <= pad2_shift_nxt;
      clr_active_r     <= clr_active_nxt;
      clr_cnt_r        <= clr_cnt_nxt;
      s1_valid_r       <= s1_valid_nxt;
      if (pal_we) begin
        palette_r[pal_idx] <= wdata;
      end
      if (s1_valid_r && s1_go) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (accept) begin
      s1_r <= s1_nxt;
    end
    if (s1_valid_r && s1_go) begin
      out_tdata_r <= {5'b0, s1_r.bad, s1_r.cwrite, s1_r.caddr, s1_r.csel, res_rdata};
      out_tuser_r <= s1_r.cspace;
    end
  end

  assign out_tdata  = out_tdata_r;
  assign out_tuser  = out_tuser_r;
  assign out_tvalid = out_valid_r;

endmodule

`default_nettype wire

FILE: src/cvbd_checker.sv
// ---------------------------------------------------------------------------
// cvbd_checker
// Port-level checks on the result stream of the bus decoder.
// ---------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module cvbd_checker
  import cvbd_pkg::*;
(
  input wire logic                   clk,
  input wire logic                   rst_n,
  input wire logic [OUT_TDATA_W-1:0] out_tdata,
  input wire logic [OUT_TUSER_W-1:0] out_tuser,
  input wire logic                   out_tvalid,
  input wire logic                   out_tready
);

  logic cart_select, cart_write, bad_register, cart_space;
  logic [7:0]  rdata;
  logic [15:0] cart_addr;

  assign rdata        = out_tdata[7:0];
  assign cart_select  = out_tdata[8];
  assign cart_addr    = out_tdata[24:9];
  assign cart_write   = out_tdata[25];
  assign bad_register = out_tdata[26];
  assign cart_space   = out_tuser[0];

  // a stalled result holds
  `CVBD_ASSERT_NEXT(a_stall_hold, clk, rst_n, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata) && $stable(out_tuser))

  // reset drops any pending result
  `CVBD_ASSERT_NEXT_ALWAYS(a_reset_idle, clk, !rst_n, !out_tvalid)

  // a forwarded write is a program-space access and returns no data
  `CVBD_ASSERT_NOW(a_cart_write, clk, rst_n, out_tvalid && cart_write, cart_select && !cart_space && rdata == 8'h00)

  // pattern-space refills stay below the video bus mirror and never write
  `CVBD_ASSERT_NOW(a_pattern, clk, rst_n, out_tvalid && cart_space, cart_select && !cart_write && cart_addr[15:14] == 2'b00)

  // a bad register write does nothing else
  `CVBD_ASSERT_NOW(a_bad_reg, clk, rst_n, out_tvalid && bad_register, !cart_select && !cart_space && rdata == 8'h00 && cart_addr == 16'h0000)

endmodule

bind cpu_video_bus_decoder_unit cvbd_checker u_cvbd_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready)
);

`default_nettype wire

FILE: bench/cpu_video_bus_decoder_unit_tb.sv
// ---------------------------------------------------------------------------
// cpu_video_bus_decoder_unit_tb
// Self-checking bench for the CPU/video bus decoder. Directed accesses walk
// the bus map, the video registers, the data port, the joypads and the
// cartridge window. Bursts of random accesses follow. A predictor in the
// bench tracks every store and register. Each result is checked field by
// field against the oldest predicted result, while both stream sides idle
// and stall at random.
// ---------------------------------------------------------------------------
module cpu_video_bus_decoder_unit_tb;
  import cvbd_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  // func code the block leaves unused: no state change, all fields zero
  localparam logic [1:0] FUNC_SPARE = 2'd3;

  // One CPU bus access as it travels on the input stream
  typedef struct packed {
    logic [1:0]  func;
    logic [15:0] addr;
    logic [7:0]  wdata;
    logic [7:0]  ext;
    logic [7:0]  pad1;
    logic [7:0]  pad2;
  } access_t;

  // One bus result as the block reports it
  typedef struct packed {
    logic [7:0]  rdata;
    logic        csel;
    logic        cspace;
    logic [15:0] caddr;
    logic        cwrite;
    logic        bad;
  } bus_result_t;

  logic                   clk;
  logic                   rst_n     = 1'b0;
  logic [IN_TDATA_W-1:0]  in_tdata  = '0;
  logic [IN_TUSER_W-1:0]  in_tuser  = '0;
  logic                   in_tvalid = 1'b0;
  logic                   in_tready;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic [OUT_TUSER_W-1:0] out_tuser;
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;

  cpu_video_bus_decoder_unit u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready)
  );

  // Predicted results, oldest first
  bus_result_t pending_results[$];
  int unsigned items_sent;
  int unsigned errors;
  bit          gaps_on;
  bit          stalls_on;

  // Shadow copy of the decoder state
  logic [7:0]  wram_m [WORK_RAM_BYTES_DEF];
  logic [7:0]  nt_m   [NAMETABLE_BYTES_DEF];
  logic [7:0]  pal_m  [PALETTE_ENTRIES_DEF];
  logic [7:0]  ctrl_m, mask_m, status_m, sprite_m, rbuf_m, pad1_m, pad2_m;
  logic [15:0] scroll_m, vaddr_m;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Generous fixed limit: the slowest legal run is well under a millisecond
  initial begin
    #5_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------

  // Palette entries at multiples of 4 fold onto the low 16 entries
  function automatic logic [4:0] pal_slot(logic [13:0] v);
    return (v[1:0] == 2'b00) ? {1'b0, v[3:0]} : v[4:0];
  endfunction

  function automatic logic [15:0] next_vaddr();
    return vaddr_m + (ctrl_m[CTRL_INC_BIT] ? VADDR_STEP_WIDE : VADDR_STEP_ONE);
  endfunction

  // Work out the result of one access and advance the shadow state
  function automatic bus_result_t predict_access(access_t a);
    bus_result_t r;
    logic [13:0] va;
    logic [7:0]  prior;
    r  = '0;
    va = vaddr_m[13:0];
    case (a.func)
      FUNC_STATUS: status_m = a.wdata;
      FUNC_READ: begin
        if (a.addr <= WRAM_TOP) begin
          r.rdata = wram_m[a.addr[10:0]];
        end else if (a.addr <= VREG_TOP) begin
          case (vreg_t'(a.addr[2:0]))
            VREG_STATUS: begin
              r.rdata  = status_m;
              status_m = status_m & STATUS_KEEP;
              vaddr_m  = '0;
            end
            VREG_DATA: begin
              prior = rbuf_m;
              if (va <= VBUS_PAT_TOP) begin
                // pattern space lives on the cartridge
                r.csel   = 1'b1;
                r.cspace = 1'b1;
                r.caddr  = {2'b00, va};
                rbuf_m   = a.ext;
              end else if (va < VBUS_PAL_BASE) begin
                rbuf_m = nt_m[va[10:0]];
              end else begin
                rbuf_m = pal_m[pal_slot(va)];
              end
              vaddr_m = next_vaddr();
              // palette reads bypass the buffer, judged on the old address
              r.rdata = (va < VBUS_PAL_BASE) ? prior : rbuf_m;
            end
            default: r.rdata = OPEN_BUS_BYTE;
          endcase
        end else if (a.addr <= IO_TOP) begin
          if (a.addr == PAD1_PORT) begin
            r.rdata = {7'd0, pad1_m[0]};
            pad1_m  = pad1_m >> 1;
          end else if (a.addr == PAD2_PORT) begin
            r.rdata = {7'd0, pad2_m[0]};
            pad2_m  = pad2_m >> 1;
          end
        end else begin
          r.rdata = a.ext;
          r.csel  = 1'b1;
          r.caddr = a.addr;
        end
      end
      FUNC_WRITE: begin
        if (a.addr <= WRAM_TOP) begin
          wram_m[a.addr[10:0]] = a.wdata;
        end else if (a.addr <= VREG_TOP) begin
          case (vreg_t'(a.addr[2:0]))
            VREG_CTRL:   ctrl_m   = a.wdata;
            VREG_MASK:   mask_m   = a.wdata;
            VREG_SPRITE: sprite_m = a.wdata;
            VREG_SCROLL: scroll_m = {scroll_m[7:0], a.wdata};
            VREG_ADDR:   vaddr_m  = {vaddr_m[7:0], a.wdata};
            VREG_DATA: begin
              // pattern-space writes are dropped
              if (va > VBUS_PAT_TOP && va < VBUS_PAL_BASE) nt_m[va[10:0]] = a.wdata;
              else if (va >= VBUS_PAL_BASE) pal_m[pal_slot(va)] = a.wdata;
              vaddr_m = next_vaddr();
            end
            default: r.bad = 1'b1;
          endcase
        end else if (a.addr <= IO_TOP) begin
          if (a.addr == PAD1_PORT && a.wdata == PAD_STROBE) begin
            pad1_m = a.pad1;
            pad2_m = a.pad2;
          end
        end else begin
          r.csel   = 1'b1;
          r.caddr  = a.addr;
          r.cwrite = 1'b1;
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Result side: random back-pressure and field-by-field checking
  // ---------------------------------------------------------------------------

  function automatic void field_ok(string name, logic [15:0] want, logic [15:0] got);
    if (got !== want) begin
      $error("%s mismatch: expected %h, got %h", name, want, got);
      errors++;
    end
  endfunction

  initial begin : result_monitor
    bus_result_t want;
    int          stall;
    stall = 0;
    forever begin
      @(posedge clk);
      if (rst_n && out_tvalid && out_tready) begin
        if (pending_results.size() == 0) begin
          $error("result with nothing expected: tdata %h tuser %h", out_tdata, out_tuser);
          errors++;
        end else begin
          want = pending_results.pop_front();
          field_ok("rdata",        16'(want.rdata),  16'(out_tdata[7:0]));
          field_ok("cart_select",  16'(want.csel),   16'(out_tdata[8]));
          field_ok("cart_addr",    want.caddr,       out_tdata[24:9]);
          field_ok("cart_write",   16'(want.cwrite), 16'(out_tdata[25]));
          field_ok("bad_register", 16'(want.bad),    16'(out_tdata[26]));
          field_ok("tdata_pad",    16'd0,            16'(out_tdata[31:27]));
          field_ok("cart_space",   16'(want.cspace), 16'(out_tuser[0]));
        end
        stall = stalls_on ? $urandom_range(0, 12) : 0;
      end
      // hold tready low for the drawn number of cycles, then raise it
      if (stall != 0) begin
        out_tready <= 1'b0;
        stall--;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Input side
  // ---------------------------------------------------------------------------

  // Send one item after a random gap; predict its result once accepted
  task automatic push_item(access_t a);
    int gap;
    gap = gaps_on ? $urandom_range(0, 12) : 0;
    if (gap != 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= a.func;
    in_tdata  <= {a.pad2, a.pad1, a.ext, a.wdata, a.addr};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    pending_results.push_back(predict_access(a));
    items_sent++;
  endtask

  // Access with random cartridge byte and pad buttons
  task automatic bus(logic [1:0] f, logic [15:0] ad, logic [7:0] wd);
    access_t a;
    a = '{func: f, addr: ad, wdata: wd, ext: 8'($urandom),
          pad1: 8'($urandom), pad2: 8'($urandom)};
    push_item(a);
  endtask

  // Drop valid and hold off until every predicted result has come back
  task automatic drain_results();
    if (in_tvalid) begin
      in_tvalid <= 1'b0;
    end
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  // Random mirror of one video register
  function automatic logic [15:0] vreg_addr(vreg_t r);
    return {3'b001, 10'($urandom), 3'(r)};
  endfunction

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  task automatic test_work_ram_mirrors();
    bus(FUNC_WRITE, 16'h0000, 8'hFF);
    bus(FUNC_READ,  16'h1800, 8'h00);   // top mirror of the first byte
    bus(FUNC_WRITE, 16'h1FFF, 8'h5A);
    bus(FUNC_READ,  16'h07FF, 8'h00);
    bus(FUNC_READ,  16'h0FFF, 8'h00);
    drain_results();
  endtask

  task automatic test_register_file();
    bus(FUNC_STATUS, 16'h0000, 8'hFF);
    bus(FUNC_READ,   16'h2002, 8'h00);  // full status, then bit 7 clears
    bus(FUNC_READ,   16'h3FFA, 8'h00);  // mirrored status port
    bus(FUNC_READ,   16'h2001, 8'h00);  // write-only register reads open bus
    bus(FUNC_WRITE,  16'h2002, 8'h55);  // unhandled: status
    bus(FUNC_WRITE,  16'h3FFC, 8'hAA);  // unhandled: sprite data
    bus(FUNC_WRITE,  16'h2003, 8'h10);
    bus(FUNC_WRITE,  16'h2005, 8'h12);
    bus(FUNC_WRITE,  16'h2005, 8'h34);
    bus(FUNC_WRITE,  16'h2001, 8'h1E);
    drain_results();
  endtask

  task automatic test_data_port();
    bus(FUNC_WRITE, 16'h2000, 8'h00);   // step of one
    bus(FUNC_WRITE, 16'h2006, 8'h3F);
    bus(FUNC_WRITE, 16'h2006, 8'h10);
    bus(FUNC_WRITE, 16'h2007, 8'hAB);   // 0x3F10 folds onto palette entry 0
    bus(FUNC_WRITE, 16'h2006, 8'h3F);
    bus(FUNC_WRITE, 16'h2006, 8'h00);
    bus(FUNC_READ,  16'h2007, 8'h00);   // palette read returns fresh byte
    bus(FUNC_WRITE, 16'h2006, 8'hFF);
    bus(FUNC_WRITE, 16'h2006, 8'hFF);   // 0xFFFF lands on 0x3FFF
    bus(FUNC_WRITE, 16'h2000, 8'h04);   // step of 32
    bus(FUNC_READ,  16'h2007, 8'h00);   // address wraps at 16 bits
    bus(FUNC_READ,  16'h2007, 8'h00);   // pattern refill via cartridge
    bus(FUNC_WRITE, 16'h2006, 8'h3E);
    bus(FUNC_WRITE, 16'h2006, 8'hFF);
    bus(FUNC_WRITE, 16'h2007, 8'h5A);   // last nametable byte
    bus(FUNC_WRITE, 16'h2006, 8'h3E);
    bus(FUNC_WRITE, 16'h2006, 8'hFF);
    bus(FUNC_READ,  16'h2007, 8'h00);   // just below palette: old buffer
    bus(FUNC_READ,  16'h2007, 8'h00);
    bus(FUNC_READ,  16'h2002, 8'h00);   // status read zeroes the address
    bus(FUNC_WRITE, 16'h2007, 8'h77);   // pattern write is dropped
    drain_results();
  endtask

  task automatic test_joypads();
    push_item('{func: FUNC_WRITE, addr: PAD1_PORT, wdata: PAD_STROBE, ext: 8'h00,
                pad1: 8'hA5, pad2: 8'h5A});
    bus(FUNC_READ, PAD1_PORT, 8'h00);
    bus(FUNC_READ, PAD1_PORT, 8'h00);
    bus(FUNC_READ, PAD2_PORT, 8'h00);
    push_item('{func: FUNC_WRITE, addr: PAD1_PORT, wdata: 8'h03, ext: 8'hFF,
                pad1: 8'hFF, pad2: 8'hFF});   // not a strobe: ignored
    bus(FUNC_WRITE, PAD2_PORT, PAD_STROBE);  // strobe only on the first port
    bus(FUNC_READ,  PAD1_PORT, 8'h00);
    bus(FUNC_READ,  16'h4000,  8'h00);
    bus(FUNC_READ,  IO_TOP,    8'h00);
    bus(FUNC_WRITE, IO_TOP,    8'hFF);
    drain_results();
  endtask

  task automatic test_cartridge();
    push_item('{func: FUNC_READ, addr: 16'h4020, wdata: 8'h00, ext: 8'hFF,
                pad1: 8'h00, pad2: 8'h00});
    push_item('{func: FUNC_READ, addr: 16'hFFFF, wdata: 8'hFF, ext: 8'h00,
                pad1: 8'hFF, pad2: 8'hFF});
    bus(FUNC_WRITE, 16'h8000, 8'hC3);
    drain_results();
  endtask

  task automatic test_spare_function();
    bus(FUNC_SPARE, 16'h4020, 8'hFF);
    bus(FUNC_SPARE, 16'h2007, 8'h00);
    bus(FUNC_SPARE, 16'h2002, 8'h00);
    bus(FUNC_READ,  16'h2007, 8'h00);   // data port untouched by the above
    drain_results();
  endtask

  // Bursts of well-formed sequences with random content, plus noise
  task automatic test_random_traffic();
    int unsigned goal, pause_at, n;
    logic [7:0]  hi;
    goal     = items_sent + 1500;
    pause_at = items_sent + 300;
    while (items_sent < goal) begin
      gaps_on   = ($urandom_range(0, 3) != 0);
      stalls_on = ($urandom_range(0, 3) != 0);
      n = $urandom_range(1, 10);
      case ($urandom_range(0, 9))
        0, 1: begin
          // work RAM, kept to a few rows at either end so reads find data
          repeat (n)
            bus($urandom_range(0, 1) ? FUNC_WRITE : FUNC_READ,
                {3'b000, 2'($urandom), ($urandom_range(0, 1) ? 7'h7F : 7'h00),
                 4'($urandom)},
                8'($urandom));
        end
        2, 3, 4: begin
          // set step and address, then a run of data-port accesses
          case ($urandom_range(0, 6))
            0: hi = 8'h20;
            1: hi = 8'h28;   // vertical mirror of 0x20
            2: hi = 8'h24;
            3: hi = 8'h3E;
            4: hi = 8'h3F;
            5: hi = 8'($urandom_range(0, 8'h1F));
            default: hi = 8'($urandom);
          endcase
          bus(FUNC_WRITE, vreg_addr(VREG_CTRL), 8'($urandom));
          bus(FUNC_WRITE, vreg_addr(VREG_ADDR), hi);
          bus(FUNC_WRITE, vreg_addr(VREG_ADDR),
              $urandom_range(0, 1) ? 8'($urandom_range(0, 15)) : 8'($urandom));
          repeat (n)
            bus($urandom_range(0, 1) ? FUNC_WRITE : FUNC_READ, vreg_addr(VREG_DATA),
                8'($urandom));
        end
        5: begin
          bus(FUNC_STATUS, 16'($urandom), 8'($urandom));
          repeat (n)
            bus($urandom_range(0, 1) ? FUNC_WRITE : FUNC_READ,
                vreg_addr(vreg_t'($urandom_range(0, 6))), 8'($urandom));
        end
        6: begin
          // strobe (mostly well formed), then shift the pads out
          bus(FUNC_WRITE, PAD1_PORT, ($urandom_range(0, 4) != 0) ? PAD_STROBE : 8'($urandom));
          repeat (n)
            bus(FUNC_READ, $urandom_range(0, 1) ? PAD2_PORT : PAD1_PORT, 8'($urandom));
        end
        7: begin
          repeat (n)
            bus($urandom_range(0, 1) ? FUNC_WRITE : FUNC_READ,
                16'($urandom_range(16'h4000, 16'hFFFF)), 8'($urandom));
        end
        8: begin
          repeat (n)
            bus($urandom_range(0, 1) ? FUNC_WRITE : FUNC_READ,
                16'h4000 | 16'(5'($urandom)), 8'($urandom));
        end
        default: begin
          repeat (n) bus(2'($urandom), 16'($urandom), 8'($urandom));
        end
      endcase
      // pause now and then until the block has caught up
      if (items_sent >= pause_at) begin
        drain_results();
        pause_at += 300;
      end
    end
    drain_results();
  endtask

  // ---------------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------------
  initial begin : stimulus
    foreach (wram_m[i]) wram_m[i] = '0;
    foreach (nt_m[i])   nt_m[i]   = '0;
    foreach (pal_m[i])  pal_m[i]  = '0;
    ctrl_m   = '0;
    mask_m   = '0;
    status_m = '0;
    sprite_m = '0;
    rbuf_m   = '0;
    pad1_m   = '0;
    pad2_m   = '0;
    scroll_m = '0;
    vaddr_m  = '0;
    items_sent = 0;
    errors     = 0;
    gaps_on    = 1'b1;
    stalls_on  = 1'b1;

    // hold reset at the start; the clearing pass then keeps tready low
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    test_work_ram_mirrors();
    test_register_file();
    test_data_port();
    test_joypads();
    test_cartridge();
    test_spare_function();
    test_random_traffic();

    // let any stray result surface before judging
    drain_results();
    repeat (20) @(posedge clk);
    if (errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
